FILE: design/lrpd_pkg.sv
package lrpd_pkg;

  // Field widths
  localparam int TIME_W   = 48;
  localparam int RATE_W   = 40;
  localparam int DLY_W    = 20;
  localparam int DRATE_W  = 20;
  localparam int GAIN_W   = 24;
  localparam int ISUM_W   = 24;
  localparam int ERR_W    = 42;
  localparam int DIF_W    = 43;
  localparam int ACC_W    = 70;
  localparam int MOP_W    = 25;
  localparam int PROD_W   = 2 * MOP_W;
  localparam int HALF_W   = 24;
  localparam int FRAC_W   = 16;
  localparam int T_W      = 33;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;
  localparam int PC_W     = 5;
  localparam int CNT_W    = 6;
  localparam int AMT_W    = 5;

  // Arithmetic constants
  localparam int DIV_STEPS  = 40;
  localparam int ISUM_LIMIT = 655360;
  localparam logic [DRATE_W-1:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [63:0] ROUND_HALF = 64'h0000_0001_0000_0000;

  // Register reset values
  localparam logic [DRATE_W-1:0] DESIRED_RST = 20'd1000;
  localparam logic [GAIN_W-1:0]  GAIN_P_RST  = 24'd65536;
  localparam logic [DLY_W-1:0]   MAXD_RST    = 20'd1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DESIRED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAXD    = 3'd4;

  // Datapath operations
  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_SAT    = 4'd1;
  localparam logic [3:0] OP_DIV    = 4'd2;
  localparam logic [3:0] OP_ERR    = 4'd3;
  localparam logic [3:0] OP_SUMDIF = 4'd4;
  localparam logic [3:0] OP_TCHK   = 4'd5;
  localparam logic [3:0] OP_DLY    = 4'd6;
  localparam logic [3:0] OP_ZERO   = 4'd7;
  localparam logic [3:0] OP_FIN    = 4'd8;

  // Multiplier operand A
  localparam logic [2:0] A_MIL  = 3'd0;
  localparam logic [2:0] A_KP   = 3'd1;
  localparam logic [2:0] A_KI   = 3'd2;
  localparam logic [2:0] A_KD   = 3'd3;
  localparam logic [2:0] A_MAXD = 3'd4;

  // Multiplier operand B
  localparam logic [3:0] B_LT_LO  = 4'd0;
  localparam logic [3:0] B_LT_HI  = 4'd1;
  localparam logic [3:0] B_ERR_LO = 4'd2;
  localparam logic [3:0] B_ERR_HI = 4'd3;
  localparam logic [3:0] B_SUM    = 4'd4;
  localparam logic [3:0] B_DIF_LO = 4'd5;
  localparam logic [3:0] B_DIF_HI = 4'd6;
  localparam logic [3:0] B_T_LO   = 4'd7;
  localparam logic [3:0] B_T_HI   = 4'd8;

  // Accumulator base
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_CLR  = 2'd1;
  localparam logic [1:0] ACC_RND  = 2'd2;

  // Jump conditions
  localparam logic [2:0] JC_NEXT   = 3'd0;
  localparam logic [2:0] JC_ALWAYS = 3'd1;
  localparam logic [2:0] JC_ZERO   = 3'd2;
  localparam logic [2:0] JC_SAT    = 3'd3;
  localparam logic [2:0] JC_LOOP   = 3'd4;
  localparam logic [2:0] JC_TOUT   = 3'd5;

  // Program addresses used as jump targets
  localparam logic [PC_W-1:0] PC_START = 5'd0;
  localparam logic [PC_W-1:0] PC_DIV   = 5'd4;
  localparam logic [PC_W-1:0] PC_ERR   = 5'd5;
  localparam logic [PC_W-1:0] PC_FIN   = 5'd18;
  localparam logic [PC_W-1:0] PC_ZERO  = 5'd19;
  localparam logic [PC_W-1:0] PC_LAST  = 5'd19;

  typedef struct packed {
    logic [3:0]      op;
    logic            mul_en;
    logic [2:0]      a_sel;
    logic [3:0]      b_sel;
    logic [1:0]      scale;
    logic            hi;
    logic [1:0]      acc_op;
    logic [2:0]      jc;
    logic [PC_W-1:0] target;
  } ucw_t;

  function automatic ucw_t uw(input logic [3:0] op, input logic mul_en,
                              input logic [2:0] a_sel, input logic [3:0] b_sel,
                              input logic [1:0] scale, input logic hi,
                              input logic [1:0] acc_op, input logic [2:0] jc,
                              input logic [PC_W-1:0] target);
    ucw_t w;
    w.op     = op;
    w.mul_en = mul_en;
    w.a_sel  = a_sel;
    w.b_sel  = b_sel;
    w.scale  = scale;
    w.hi     = hi;
    w.acc_op = acc_op;
    w.jc     = jc;
    w.target = target;
    return w;
  endfunction

  // Control program, one word per step
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    unique case (pc)
      // count * 1e6 in two halves, bail out on zero elapsed time
      5'd0:  w = uw(OP_NOP,    1'b1, A_MIL,  B_LT_LO,  2'd0, 1'b0, ACC_CLR,  JC_ZERO,   PC_ZERO);
      5'd1:  w = uw(OP_NOP,    1'b1, A_MIL,  B_LT_HI,  2'd0, 1'b1, ACC_HOLD, JC_NEXT,   PC_START);
      5'd2:  w = uw(OP_NOP,    1'b0, A_MIL,  B_LT_LO,  2'd0, 1'b0, ACC_HOLD, JC_NEXT,   PC_START);
      // saturation check, then restoring division
      5'd3:  w = uw(OP_SAT,    1'b0, A_MIL,  B_LT_LO,  2'd0, 1'b0, ACC_HOLD, JC_SAT,    PC_ERR);
      5'd4:  w = uw(OP_DIV,    1'b0, A_MIL,  B_LT_LO,  2'd0, 1'b0, ACC_HOLD, JC_LOOP,   PC_DIV);
      // error, integral and difference
      5'd5:  w = uw(OP_ERR,    1'b0, A_MIL,  B_LT_LO,  2'd0, 1'b0, ACC_HOLD, JC_NEXT,   PC_START);
      5'd6:  w = uw(OP_SUMDIF, 1'b0, A_MIL,  B_LT_LO,  2'd0, 1'b0, ACC_CLR,  JC_NEXT,   PC_START);
      // T = 2*Kp*e + 4*Ki*s + Kd*d
      5'd7:  w = uw(OP_NOP,    1'b1, A_KP,   B_ERR_LO, 2'd1, 1'b0, ACC_HOLD, JC_NEXT,   PC_START);
      5'd8:  w = uw(OP_NOP,    1'b1, A_KP,   B_ERR_HI, 2'd1, 1'b1, ACC_HOLD, JC_NEXT,   PC_START);
      5'd9:  w = uw(OP_NOP,    1'b1, A_KI,   B_SUM,    2'd2, 1'b0, ACC_HOLD, JC_NEXT,   PC_START);
      5'd10: w = uw(OP_NOP,    1'b1, A_KD,   B_DIF_LO, 2'd0, 1'b0, ACC_HOLD, JC_NEXT,   PC_START);
      5'd11: w = uw(OP_NOP,    1'b1, A_KD,   B_DIF_HI, 2'd0, 1'b1, ACC_HOLD, JC_NEXT,   PC_START);
      5'd12: w = uw(OP_NOP,    1'b0, A_KD,   B_DIF_LO, 2'd0, 1'b0, ACC_HOLD, JC_NEXT,   PC_START);
      // clamp to [0,1], else scale by max delay with rounding
      5'd13: w = uw(OP_TCHK,   1'b0, A_MAXD, B_T_LO,   2'd0, 1'b0, ACC_RND,  JC_TOUT,   PC_FIN);
      5'd14: w = uw(OP_NOP,    1'b1, A_MAXD, B_T_LO,   2'd0, 1'b0, ACC_HOLD, JC_NEXT,   PC_START);
      5'd15: w = uw(OP_NOP,    1'b1, A_MAXD, B_T_HI,   2'd0, 1'b1, ACC_HOLD, JC_NEXT,   PC_START);
      5'd16: w = uw(OP_NOP,    1'b0, A_MAXD, B_T_LO,   2'd0, 1'b0, ACC_HOLD, JC_NEXT,   PC_START);
      5'd17: w = uw(OP_DLY,    1'b0, A_MAXD, B_T_LO,   2'd0, 1'b0, ACC_HOLD, JC_NEXT,   PC_START);
      5'd18: w = uw(OP_FIN,    1'b0, A_MIL,  B_LT_LO,  2'd0, 1'b0, ACC_HOLD, JC_NEXT,   PC_START);
      5'd19: w = uw(OP_ZERO,   1'b0, A_MIL,  B_LT_LO,  2'd0, 1'b0, ACC_HOLD, JC_ALWAYS, PC_FIN);
      default: w = uw(OP_FIN,  1'b0, A_MIL,  B_LT_LO,  2'd0, 1'b0, ACC_HOLD, JC_NEXT,   PC_START);
    endcase
    return w;
  endfunction

endpackage

FILE: design/lrpd_if.sv
// Loop event channel
interface lrpd_in_if;
  logic                          valid;
  logic                          ready;
  logic [lrpd_pkg::TIME_W-1:0]   now_us;

  modport source (output valid, output now_us, input ready);
  modport sink   (input valid, input now_us, output ready);
endinterface

// Delay result channel
interface lrpd_out_if;
  logic                          valid;
  logic                          ready;
  logic [lrpd_pkg::DLY_W-1:0]    delay_us;
  logic [lrpd_pkg::RATE_W-1:0]   measured_rate;
  logic                          zero_elapsed;

  modport source (output valid, output delay_us, output measured_rate,
                  output zero_elapsed, input ready);
  modport sink   (input valid, input delay_us, input measured_rate,
                  input zero_elapsed, output ready);
endinterface

// Register write channel
interface lrpd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lrpd_pkg::CFG_IDX_W-1:0]  index;
  logic [lrpd_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/loop_rate_pid_delay.sv
// Loop rate PID controller: turns loop-completion timestamps into a delay.
//
// in_ch carries one word per loop event with a microsecond timestamp. The
// first event after reset only records the start time and gives no result.
// Each later event gives one word on out_ch: the delay, the measured rate in
// Q24.16 and a flag set when no time has elapsed since the first event.
// cfg_ch writes the five control registers (index 0..4, others ignored);
// it is always ready and is meant to be written while the block is idle.
//
// A saturated rate skips the divider, a clamped controller output skips the
// delay scaling, and zero elapsed time skips the divider and the PID terms.
// The 40-step restoring divider dominates; everything else runs through one
// shared 25x25 multiplier stepped by the control program. One event is
// processed at a time; a new event can be taken as soon as the result lands
// in the output register, even if the receiver has not taken it yet. If
// that register is still full when the next result is ready, the program
// waits.
// Synchronous reset clears the registers to their defaults, the start time,
// the loop count and the PID state.
module loop_rate_pid_delay (
  input  logic        clk,
  input  logic        rst_n,
  lrpd_in_if.sink     in_ch,
  lrpd_out_if.source  out_ch,
  lrpd_cfg_if.sink    cfg_ch
);

  localparam int TIME_W = lrpd_pkg::TIME_W;
  localparam int RATE_W = lrpd_pkg::RATE_W;
  localparam int DLY_W  = lrpd_pkg::DLY_W;
  localparam int GAIN_W = lrpd_pkg::GAIN_W;
  localparam int ISUM_W = lrpd_pkg::ISUM_W;
  localparam int ERR_W  = lrpd_pkg::ERR_W;
  localparam int DIF_W  = lrpd_pkg::DIF_W;
  localparam int ACC_W  = lrpd_pkg::ACC_W;
  localparam int MOP_W  = lrpd_pkg::MOP_W;
  localparam int PROD_W = lrpd_pkg::PROD_W;
  localparam int HALF_W = lrpd_pkg::HALF_W;
  localparam int FRAC_W = lrpd_pkg::FRAC_W;
  localparam int T_W    = lrpd_pkg::T_W;
  localparam int PC_W   = lrpd_pkg::PC_W;
  localparam int CNT_W  = lrpd_pkg::CNT_W;
  localparam int AMT_W  = lrpd_pkg::AMT_W;

  localparam logic signed [DIF_W-1:0]  ISUM_POS   = DIF_W'(lrpd_pkg::ISUM_LIMIT);
  localparam logic signed [DIF_W-1:0]  ISUM_NEG   = -ISUM_POS;
  localparam logic signed [ISUM_W-1:0] ISUM_POS_S = ISUM_W'(lrpd_pkg::ISUM_LIMIT);
  localparam logic signed [ISUM_W-1:0] ISUM_NEG_S = -ISUM_POS_S;

  // Control registers
  logic [lrpd_pkg::DRATE_W-1:0] desired_r, desired_nxt;
  logic signed [GAIN_W-1:0]     gain_p_r, gain_p_nxt;
  logic signed [GAIN_W-1:0]     gain_i_r, gain_i_nxt;
  logic signed [GAIN_W-1:0]     gain_d_r, gain_d_nxt;
  logic [DLY_W-1:0]             maxd_r, maxd_nxt;

  // Loop state
  logic                      started_r, started_nxt;
  logic [TIME_W-1:0]         start_time_r, start_time_nxt;
  logic [TIME_W-1:0]         loop_total_r, loop_total_nxt;
  logic signed [ISUM_W-1:0]  isum_r, isum_nxt;
  logic signed [ERR_W-1:0]   prev_err_r, prev_err_nxt;

  // Sequencer
  logic                busy_r, busy_nxt;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  lrpd_pkg::ucw_t      cw;
  logic                jump;

  // Datapath
  logic [TIME_W-1:0]         elapsed_r, elapsed_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [PROD_W-1:0]  p_r, p_nxt;
  logic                      p_vld_r, p_vld_nxt;
  logic [AMT_W-1:0]          p_amt_r, p_amt_nxt;
  logic [TIME_W-1:0]         rem_r, rem_nxt;
  logic [RATE_W-1:0]         quo_r, quo_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [ISUM_W-1:0]  sum_r, sum_nxt;
  logic signed [DIF_W-1:0]   dif_r, dif_nxt;
  logic [T_W-1:0]            t_r, t_nxt;
  logic [DLY_W-1:0]          delay_r, delay_nxt;
  logic                      zflag_r, zflag_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [DLY_W-1:0]   out_delay_r, out_delay_nxt;
  logic [RATE_W-1:0]  out_rate_r, out_rate_nxt;
  logic               out_zero_r, out_zero_nxt;

  logic                      in_acc, cfg_acc;
  logic signed [MOP_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]   p_ext, addend, acc_base;
  logic                      sat_hit;
  logic [TIME_W:0]           r_sh, r_dif;
  logic                      r_ge;
  logic signed [DIF_W-1:0]   sum_full;
  logic signed [ISUM_W-1:0]  sum_clamp;
  logic                      t_low, t_high;

  assign cw      = lrpd_pkg::ucode(pc_r);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready          = !busy_r;
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.delay_us      = out_delay_r;
  assign out_ch.measured_rate = out_rate_r;
  assign out_ch.zero_elapsed  = out_zero_r;

  // Shared multiplier operands
  always_comb begin
    unique case (cw.a_sel)
      lrpd_pkg::A_MIL:  mul_a = $signed(MOP_W'(lrpd_pkg::USEC_PER_SEC));
      lrpd_pkg::A_KP:   mul_a = $signed({gain_p_r[GAIN_W-1], gain_p_r});
      lrpd_pkg::A_KI:   mul_a = $signed({gain_i_r[GAIN_W-1], gain_i_r});
      lrpd_pkg::A_KD:   mul_a = $signed({gain_d_r[GAIN_W-1], gain_d_r});
      lrpd_pkg::A_MAXD: mul_a = $signed(MOP_W'(maxd_r));
      default:          mul_a = '0;
    endcase
    unique case (cw.b_sel)
      lrpd_pkg::B_LT_LO:  mul_b = $signed({1'b0, loop_total_r[HALF_W-1:0]});
      lrpd_pkg::B_LT_HI:  mul_b = $signed({1'b0, loop_total_r[TIME_W-1:HALF_W]});
      lrpd_pkg::B_ERR_LO: mul_b = $signed({1'b0, err_r[HALF_W-1:0]});
      lrpd_pkg::B_ERR_HI: mul_b = $signed({{(MOP_W-ERR_W+HALF_W){err_r[ERR_W-1]}},
                                           err_r[ERR_W-1:HALF_W]});
      lrpd_pkg::B_SUM:    mul_b = $signed({sum_r[ISUM_W-1], sum_r});
      lrpd_pkg::B_DIF_LO: mul_b = $signed({1'b0, dif_r[HALF_W-1:0]});
      lrpd_pkg::B_DIF_HI: mul_b = $signed({{(MOP_W-DIF_W+HALF_W){dif_r[DIF_W-1]}},
                                           dif_r[DIF_W-1:HALF_W]});
      lrpd_pkg::B_T_LO:   mul_b = $signed({1'b0, t_r[HALF_W-1:0]});
      lrpd_pkg::B_T_HI:   mul_b = $signed(MOP_W'(t_r[T_W-1:HALF_W]));
      default:            mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Registered product aligned into the accumulator
  assign p_ext  = $signed({{(ACC_W-PROD_W){p_r[PROD_W-1]}}, p_r});
  assign addend = p_ext <<< p_amt_r;

  always_comb begin
    unique case (cw.acc_op)
      lrpd_pkg::ACC_HOLD: acc_base = acc_r;
      lrpd_pkg::ACC_CLR:  acc_base = '0;
      lrpd_pkg::ACC_RND:  acc_base = $signed(ACC_W'(lrpd_pkg::ROUND_HALF));
      default:            acc_base = acc_r;
    endcase
  end

  // Rate saturates when count*1e6 >= elapsed * 2^24
  assign sat_hit = {2'b00, acc_r} >= {elapsed_r, {HALF_W{1'b0}}};

  // One restoring division step
  assign r_sh  = {rem_r, quo_r[RATE_W-1]};
  assign r_ge  = r_sh >= {1'b0, elapsed_r};
  assign r_dif = r_sh - {1'b0, elapsed_r};

  // Integral with clamp
  assign sum_full = $signed({{(DIF_W-ISUM_W){isum_r[ISUM_W-1]}}, isum_r})
                  + $signed({err_r[ERR_W-1], err_r});
  always_comb begin
    if (sum_full > ISUM_POS) begin
      sum_clamp = ISUM_POS_S;
    end else if (sum_full < ISUM_NEG) begin
      sum_clamp = ISUM_NEG_S;
    end else begin
      sum_clamp = sum_full[ISUM_W-1:0];
    end
  end

  // Controller output range: T <= 0 or T >= 2^33
  assign t_low  = acc_r[ACC_W-1] || (acc_r == '0);
  assign t_high = !acc_r[ACC_W-1] && (acc_r[ACC_W-2:T_W] != '0);

  // Jump decision
  always_comb begin
    unique case (cw.jc)
      lrpd_pkg::JC_NEXT:   jump = 1'b0;
      lrpd_pkg::JC_ALWAYS: jump = 1'b1;
      lrpd_pkg::JC_ZERO:   jump = (elapsed_r == '0);
      lrpd_pkg::JC_SAT:    jump = sat_hit;
      lrpd_pkg::JC_LOOP:   jump = (cnt_r != '0);
      lrpd_pkg::JC_TOUT:   jump = t_low || t_high;
      default:             jump = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    desired_nxt    = desired_r;
    gain_p_nxt     = gain_p_r;
    gain_i_nxt     = gain_i_r;
    gain_d_nxt     = gain_d_r;
    maxd_nxt       = maxd_r;
    started_nxt    = started_r;
    start_time_nxt = start_time_r;
    loop_total_nxt = loop_total_r;
    isum_nxt       = isum_r;
    prev_err_nxt   = prev_err_r;
    busy_nxt       = busy_r;
    pc_nxt         = pc_r;
    cnt_nxt        = cnt_r;
    elapsed_nxt    = elapsed_r;
    acc_nxt        = acc_r;
    p_nxt          = p_r;
    p_vld_nxt      = 1'b0;
    p_amt_nxt      = p_amt_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    err_nxt        = err_r;
    sum_nxt        = sum_r;
    dif_nxt        = dif_r;
    t_nxt          = t_r;
    delay_nxt      = delay_r;
    zflag_nxt      = zflag_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_delay_nxt  = out_delay_r;
    out_rate_nxt   = out_rate_r;
    out_zero_nxt   = out_zero_r;

    // Register writes
    if (cfg_acc) begin
      unique case (cfg_ch.index)
        lrpd_pkg::REG_DESIRED: desired_nxt = cfg_ch.data[lrpd_pkg::DRATE_W-1:0];
        lrpd_pkg::REG_GAIN_P:  gain_p_nxt  = $signed(cfg_ch.data[GAIN_W-1:0]);
        lrpd_pkg::REG_GAIN_I:  gain_i_nxt  = $signed(cfg_ch.data[GAIN_W-1:0]);
        lrpd_pkg::REG_GAIN_D:  gain_d_nxt  = $signed(cfg_ch.data[GAIN_W-1:0]);
        lrpd_pkg::REG_MAXD:    maxd_nxt    = cfg_ch.data[DLY_W-1:0];
        default: ;
      endcase
    end

    // Event intake: first one records the start, later ones run the program
    if (in_acc) begin
      if (!started_r) begin
        started_nxt    = 1'b1;
        start_time_nxt = in_ch.now_us;
      end else begin
        loop_total_nxt = loop_total_r + TIME_W'(1);
        elapsed_nxt    = in_ch.now_us - start_time_r;
        busy_nxt       = 1'b1;
        pc_nxt         = lrpd_pkg::PC_START;
        zflag_nxt      = 1'b0;
      end
    end

    if (busy_r) begin
      // multiplier and accumulator
      if (cw.mul_en) begin
        p_nxt     = mul_p;
        p_vld_nxt = 1'b1;
        p_amt_nxt = (cw.hi ? AMT_W'(HALF_W) : '0) + AMT_W'(cw.scale);
      end
      acc_nxt = acc_base + (p_vld_r ? addend : '0);

      unique case (cw.op)
        lrpd_pkg::OP_NOP: ;
        lrpd_pkg::OP_SAT: begin
          if (sat_hit) begin
            quo_nxt = '1;
          end else begin
            rem_nxt = {2'b00, acc_r[ACC_W-1:HALF_W]};
            quo_nxt = {acc_r[HALF_W-1:0], {FRAC_W{1'b0}}};
            cnt_nxt = CNT_W'(lrpd_pkg::DIV_STEPS - 1);
          end
        end
        lrpd_pkg::OP_DIV: begin
          rem_nxt = r_ge ? r_dif[TIME_W-1:0] : r_sh[TIME_W-1:0];
          quo_nxt = {quo_r[RATE_W-2:0], r_ge};
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        lrpd_pkg::OP_ERR: begin
          err_nxt = $signed({{(ERR_W-lrpd_pkg::DRATE_W-FRAC_W){1'b0}}, desired_r,
                             {FRAC_W{1'b0}}})
                  - $signed({{(ERR_W-RATE_W){1'b0}}, quo_r});
        end
        lrpd_pkg::OP_SUMDIF: begin
          sum_nxt      = sum_clamp;
          dif_nxt      = $signed({err_r[ERR_W-1], err_r})
                       - $signed({prev_err_r[ERR_W-1], prev_err_r});
          isum_nxt     = sum_clamp;
          prev_err_nxt = err_r;
        end
        lrpd_pkg::OP_TCHK: begin
          if (t_low) begin
            delay_nxt = '0;
          end else if (t_high) begin
            delay_nxt = maxd_r;
          end
          t_nxt = acc_r[T_W-1:0];
        end
        lrpd_pkg::OP_DLY: begin
          delay_nxt = acc_r[T_W+DLY_W-1:T_W];
        end
        lrpd_pkg::OP_ZERO: begin
          delay_nxt = '0;
          quo_nxt   = '0;
          zflag_nxt = 1'b1;
        end
        lrpd_pkg::OP_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_nxt = 1'b1;
            out_delay_nxt = delay_r;
            out_rate_nxt  = quo_r;
            out_zero_nxt  = zflag_r;
            busy_nxt      = 1'b0;
          end
        end
        default: ;
      endcase

      // step counter, held on the final step until the result is placed
      if (cw.op == lrpd_pkg::OP_FIN) begin
        pc_nxt = pc_r;
      end else if (jump) begin
        pc_nxt = cw.target;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desired_r    <= lrpd_pkg::DESIRED_RST;
      gain_p_r     <= $signed(lrpd_pkg::GAIN_P_RST);
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      maxd_r       <= lrpd_pkg::MAXD_RST;
      started_r    <= 1'b0;
      start_time_r <= '0;
      loop_total_r <= '0;
      isum_r       <= '0;
      prev_err_r   <= '0;
      busy_r       <= 1'b0;
      pc_r         <= lrpd_pkg::PC_START;
      p_vld_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      desired_r    <= desired_nxt;
      gain_p_r     <= gain_p_nxt;
      gain_i_r     <= gain_i_nxt;
      gain_d_r     <= gain_d_nxt;
      maxd_r       <= maxd_nxt;
      started_r    <= started_nxt;
      start_time_r <= start_time_nxt;
      loop_total_r <= loop_total_nxt;
      isum_r       <= isum_nxt;
      prev_err_r   <= prev_err_nxt;
      busy_r       <= busy_nxt;
      pc_r         <= pc_nxt;
      p_vld_r      <= p_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    elapsed_r   <= elapsed_nxt;
    acc_r       <= acc_nxt;
    p_r         <= p_nxt;
    p_amt_r     <= p_amt_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    err_r       <= err_nxt;
    sum_r       <= sum_nxt;
    dif_r       <= dif_nxt;
    t_r         <= t_nxt;
    delay_r     <= delay_nxt;
    zflag_r     <= zflag_nxt;
    out_delay_r <= out_delay_nxt;
    out_rate_r  <= out_rate_nxt;
    out_zero_r  <= out_zero_nxt;
  end

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cw.op == lrpd_pkg::OP_DIV) |-> (rem_r < elapsed_r))
    else $error("divider remainder not below divisor");

  // Integral never leaves its clamp
  a_isum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (isum_r <= ISUM_POS_S) && (isum_r >= ISUM_NEG_S))
    else $error("integral sum outside clamp");

  // Accumulator is settled when it is inspected
  a_acc_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (cw.op == lrpd_pkg::OP_SAT || cw.op == lrpd_pkg::OP_TCHK ||
                cw.op == lrpd_pkg::OP_DLY)) |-> !p_vld_r)
    else $error("product pending while accumulator is read");

  // Zero elapsed words carry no delay and no rate
  a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_zero_r) |-> (out_delay_r == '0 && out_rate_r == '0))
    else $error("zero elapsed word with nonzero payload");

  // The program only runs once a start time exists
  a_run_started: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(started_r))
    else $error("program started before the first event");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int TIME_W    = lrpd_pkg::TIME_W;
  localparam int RATE_W    = lrpd_pkg::RATE_W;
  localparam int DLY_W     = lrpd_pkg::DLY_W;
  localparam int DRATE_W   = lrpd_pkg::DRATE_W;
  localparam int GAIN_W    = lrpd_pkg::GAIN_W;
  localparam int FRAC_W    = lrpd_pkg::FRAC_W;
  localparam int CFG_IDX_W = lrpd_pkg::CFG_IDX_W;
  localparam int CFG_DAT_W = lrpd_pkg::CFG_DAT_W;

  localparam int DRAIN_PAD = 80;      // covers the full program path
  localparam int SEGMENTS  = 8;
  localparam int SEG_WORDS = 230;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam logic [RATE_W-1:0]    RATE_SAT   = '1;
  localparam logic signed [79:0]   T_FULL     = 80'sh2_0000_0000;
  localparam logic [TIME_W-1:0]    EPOCH      = 48'd1000000;

  typedef struct packed {
    logic [DLY_W-1:0]  delay_us;
    logic [RATE_W-1:0] measured_rate;
    logic              zero_elapsed;
  } delay_word_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DAT_W-1:0]  reg_data;
    logic [TIME_W-1:0]     now;
    bit                    typed;
    delay_word_t           word;
  } stim_row_t;

  logic clk;
  logic rst_n;

  lrpd_in_if  in_ch ();
  lrpd_out_if out_ch ();
  lrpd_cfg_if cfg_ch ();

  loop_rate_pid_delay i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Controller registers as the predictor sees them
  logic [DRATE_W-1:0]       desired_rate;
  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic [DLY_W-1:0]         delay_cap;

  // Loop tracking and PID state
  bit                  started_flag;
  logic [TIME_W-1:0]   start_time;
  logic [TIME_W-1:0]   loop_total;
  logic signed [79:0]  integral_sum;
  logic signed [79:0]  prev_error;

  delay_word_t pending_words[$];
  stim_row_t   script[$];
  int          bad_words;
  int          send_idle_pct;
  int          stall_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Delay word for one loop event; returns 0 when the event gives no word
  function automatic bit predict_delay(input logic [TIME_W-1:0] now, output delay_word_t w);
    logic [TIME_W-1:0]  span;
    logic [83:0]        num, quo;
    logic [RATE_W-1:0]  rate;
    logic signed [79:0] err, isum, diff, tsum;
    logic [63:0]        scaled;
    w = '0;
    if (!started_flag) begin
      started_flag = 1'b1;
      start_time   = now;
      return 1'b0;
    end
    loop_total = loop_total + 1'b1;
    span = now - start_time;
    if (span == '0) begin
      // no time passed: flag only, PID state untouched
      w.zero_elapsed = 1'b1;
      return 1'b1;
    end
    num  = (84'(loop_total) * 84'(lrpd_pkg::USEC_PER_SEC)) << FRAC_W;
    quo  = num / 84'(span);
    rate = (quo > 84'(RATE_SAT)) ? RATE_SAT : quo[RATE_W-1:0];
    // error, clamped integral, difference
    err  = $signed(80'({desired_rate, 16'h0000})) - $signed(80'(rate));
    isum = integral_sum + err;
    if (isum > lrpd_pkg::ISUM_LIMIT) isum = lrpd_pkg::ISUM_LIMIT;
    else if (isum < -lrpd_pkg::ISUM_LIMIT) isum = -lrpd_pkg::ISUM_LIMIT;
    diff = err - prev_error;
    integral_sum = isum;
    prev_error   = err;
    // tsum = 2*y*2^32, y clamped to [0,1]
    tsum = 2 * kp * err + 4 * ki * isum + kd * diff;
    if (tsum <= 0) begin
      w.delay_us = '0;
    end else if (tsum >= T_FULL) begin
      w.delay_us = delay_cap;
    end else begin
      scaled = (64'(delay_cap) * 64'(tsum[32:0]) + lrpd_pkg::ROUND_HALF) >> 33;
      w.delay_us = scaled[DLY_W-1:0];
    end
    w.measured_rate = rate;
    return 1'b1;
  endfunction

  // Register write, predictor follows at the handshake
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      lrpd_pkg::REG_DESIRED: desired_rate = data[DRATE_W-1:0];
      lrpd_pkg::REG_GAIN_P:  kp = data;
      lrpd_pkg::REG_GAIN_I:  ki = data;
      lrpd_pkg::REG_GAIN_D:  kd = data;
      lrpd_pkg::REG_MAXD:    delay_cap = data[DLY_W-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // One loop event; valid stays up after accept until the next call decides
  task automatic send_event(input logic [TIME_W-1:0] now, input bit typed,
                            input delay_word_t typed_word);
    delay_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.now_us <= now;
    do @(posedge clk); while (!in_ch.ready);
    if (predict_delay(now, w))
      pending_words.push_back(typed ? typed_word : w);
  endtask

  // Wait until every word is back and the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DAT_W-1:0] data);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg   = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic stim_row_t event_row(input logic [TIME_W-1:0] now);
    stim_row_t r;
    r = '{default: '0};
    r.now = now;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [TIME_W-1:0] now,
                                          input logic [DLY_W-1:0] dly,
                                          input logic [RATE_W-1:0] rate,
                                          input logic zero);
    stim_row_t r;
    r = event_row(now);
    r.typed = 1'b1;
    r.word  = '{delay_us: dly, measured_rate: rate, zero_elapsed: zero};
    return r;
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_gain();
    int g;
    case ($urandom_range(9))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return '0;
      3, 4: return 24'($urandom);
      5: return lrpd_pkg::GAIN_P_RST;
      default: begin
        g = $urandom_range(4096);
        return 24'($urandom_range(1) ? -g : g);
      end
    endcase
  endfunction

  // upper data bits are don't-care for 20 bit registers, so randomize them
  function automatic logic [CFG_DAT_W-1:0] pick_desired();
    logic [DRATE_W-1:0] v;
    case ($urandom_range(7))
      0: v = '0;
      1: v = 20'd1;
      2: v = lrpd_pkg::USEC_PER_SEC;
      3: v = 20'($urandom_range(1, 1000000));
      default: v = 20'($urandom_range(1, 2000));
    endcase
    return {4'($urandom), v};
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_delay_cap();
    logic [DLY_W-1:0] v;
    case ($urandom_range(7))
      0: v = '0;
      1: v = 20'd1000000;
      2: v = 20'hFFFFF;
      3: v = 20'($urandom_range(1000000));
      default: v = 20'($urandom_range(1, 5000));
    endcase
    return {4'($urandom), v};
  endfunction

  // Mostly timestamps near the pace of the desired rate, some noise
  function automatic logic [TIME_W-1:0] next_now();
    logic [63:0] span, jit;
    int          roll;
    roll = $urandom_range(99);
    if (roll < 8) return start_time;
    if (roll < 15) return start_time - TIME_W'($urandom_range(1, 1 << 20));
    if (roll < 25) return {16'($urandom), 32'($urandom)};
    if (desired_rate != '0)
      span = (64'(loop_total) + 64'd1) * 64'(lrpd_pkg::USEC_PER_SEC) / 64'(desired_rate);
    else
      span = 64'($urandom_range(1, 1 << 30));
    jit = span >> (5 * $urandom_range(1, 5));
    jit = 64'($urandom) % (jit + 64'd1);
    return start_time + TIME_W'($urandom_range(1) ? span + jit : span - jit);
  endfunction

  task automatic flag_bad(input string note, input delay_word_t want, input delay_word_t got);
    if (bad_words < 10)
      $display("%t %s: want delay %0d rate %0d zero %0d, got delay %0d rate %0d zero %0d",
               $realtime, note, want.delay_us, want.measured_rate, want.zero_elapsed,
               got.delay_us, got.measured_rate, got.zero_elapsed);
    bad_words++;
  endtask

  // Result side: check each word, stall at random
  always @(posedge clk) begin
    delay_word_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.delay_us      = out_ch.delay_us;
      got.measured_rate = out_ch.measured_rate;
      got.zero_elapsed  = out_ch.zero_elapsed;
      if (pending_words.size() == 0) begin
        flag_bad("unexpected word", '0, got);
      end else begin
        want = pending_words.pop_front();
        if (got.delay_us !== want.delay_us || got.measured_rate !== want.measured_rate ||
            got.zero_elapsed !== want.zero_elapsed)
          flag_bad("word mismatch", want, got);
      end
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Stimulus
  initial begin
    int  seg, n;
    bit  last_cfg;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.now_us  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    bad_words     = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    desired_rate  = lrpd_pkg::DESIRED_RST;
    kp            = lrpd_pkg::GAIN_P_RST;
    ki            = '0;
    kd            = '0;
    delay_cap     = lrpd_pkg::MAXD_RST;
    started_flag  = 1'b0;
    start_time    = '0;
    loop_total    = '0;
    integral_sum  = '0;
    prev_error    = '0;
    last_cfg      = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first event, zero elapsed, wrap, register extremes, rate saturation
    script.push_back(event_row(EPOCH));
    script.push_back(typed_row(EPOCH, '0, '0, 1'b1));
    script.push_back(typed_row(EPOCH + 48'd1000000, 20'd1000, 40'd131072, 1'b0));
    script.push_back(typed_row(EPOCH + 48'd1, '0, 40'd196608000000, 1'b0));
    script.push_back(typed_row(48'd0, 20'd1000, '0, 1'b0));
    script.push_back(typed_row(48'hFFFF_FFFF_FFFF, 20'd1000, '0, 1'b0));
    script.push_back(cfg_row(lrpd_pkg::REG_MAXD, 24'h0FFFFF));
    script.push_back(typed_row(EPOCH + 48'd2000000, 20'hFFFFF, 40'd196608, 1'b0));
    script.push_back(cfg_row(lrpd_pkg::REG_DESIRED, 24'hF00000));
    script.push_back(event_row(EPOCH + 48'd3000000));
    script.push_back(cfg_row(lrpd_pkg::REG_GAIN_P, 24'h800000));
    script.push_back(event_row(EPOCH + 48'd4000000));
    script.push_back(cfg_row(lrpd_pkg::REG_DESIRED, 24'd1000000));
    script.push_back(cfg_row(lrpd_pkg::REG_GAIN_P, 24'h7FFFFF));
    script.push_back(event_row(EPOCH + 48'd500000));
    script.push_back(cfg_row(lrpd_pkg::REG_GAIN_P, 24'h000000));
    script.push_back(cfg_row(lrpd_pkg::REG_GAIN_I, 24'h7FFFFF));
    script.push_back(event_row(EPOCH + 48'd5000000));
    script.push_back(cfg_row(lrpd_pkg::REG_GAIN_I, 24'h800000));
    script.push_back(cfg_row(lrpd_pkg::REG_GAIN_D, 24'h7FFFFF));
    script.push_back(event_row(EPOCH + 48'd1500000));
    script.push_back(cfg_row(lrpd_pkg::REG_GAIN_D, 24'h800000));
    script.push_back(cfg_row(lrpd_pkg::REG_MAXD, 24'h000000));
    script.push_back(event_row(EPOCH + 48'd6000000));
    // out-of-list index must be ignored; then back to defaults
    script.push_back(cfg_row(REG_UNUSED, 24'hABCDEF));
    script.push_back(cfg_row(lrpd_pkg::REG_DESIRED, 24'd1000));
    script.push_back(cfg_row(lrpd_pkg::REG_GAIN_P, 24'd65536));
    script.push_back(cfg_row(lrpd_pkg::REG_GAIN_I, 24'd0));
    script.push_back(cfg_row(lrpd_pkg::REG_GAIN_D, 24'd0));
    script.push_back(cfg_row(lrpd_pkg::REG_MAXD, 24'd1000));
    script.push_back(typed_row(EPOCH, '0, '0, 1'b1));
    // one microsecond elapsed: count 16 is the last unsaturated rate
    script.push_back(event_row(EPOCH + 48'd1));
    script.push_back(event_row(EPOCH + 48'd1));
    script.push_back(typed_row(EPOCH + 48'd1, '0, 40'd1048576000000, 1'b0));
    script.push_back(typed_row(EPOCH + 48'd1, '0, RATE_SAT, 1'b0));

    foreach (script[k]) begin
      if (script[k].is_cfg) begin
        if (!last_cfg) settle();
        write_reg(script[k].reg_idx, script[k].reg_data);
      end else begin
        send_event(script[k].now, script[k].typed, script[k].word);
      end
      last_cfg = script[k].is_cfg;
    end

    // Random: new register set and idle pattern per segment
    for (seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      write_reg(lrpd_pkg::REG_DESIRED, pick_desired());
      write_reg(lrpd_pkg::REG_GAIN_P, pick_gain());
      write_reg(lrpd_pkg::REG_GAIN_I, pick_gain());
      write_reg(lrpd_pkg::REG_GAIN_D, pick_gain());
      write_reg(lrpd_pkg::REG_MAXD, pick_delay_cap());
      if (seg % 3 == 0) write_reg(REG_UNUSED, 24'($urandom));
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      for (n = 0; n < SEG_WORDS; n++)
        send_event(next_now(), 1'b0, '0);
    end

    settle();
    if (bad_words == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
